// ===== design/twc_pkg.sv =====
// shared types, codes and constants of the text window console
package twc_pkg;

	localparam int SCREEN_COLS_DEF = 80;
	localparam int SCREEN_ROWS_DEF = 25;

	localparam int COLW   = 9;
	localparam int ROWW   = 7;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_SPACE   = 8'h20;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [6:0] RST_WIN_COL    = 7'd0;
	localparam logic [4:0] RST_WIN_ROW    = 5'd0;
	localparam logic [6:0] RST_WIN_WIDTH  = 7'd80;
	localparam logic [4:0] RST_WIN_HEIGHT = 5'd25;

	typedef enum logic [1:0] {
		REG_WIN_COL    = 2'd0,
		REG_WIN_ROW    = 2'd1,
		REG_WIN_WIDTH  = 2'd2,
		REG_WIN_HEIGHT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_CLEAR,
		OP_READ,
		OP_NONE
	} op_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_PUT,
		ST_LINE,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_BLANK,
		ST_FILL,
		ST_RD,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [6:0] win_col;
		logic [4:0] win_row;
		logic [6:0] win_width;
		logic [4:0] win_height;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] code;
		logic [6:0] rcol;
		logic [4:0] rrow;
	} cmd_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [6:0] cursor_col;
		logic [4:0] cursor_line;
		logic       scrolled;
	} res_t;

endpackage

// ===== design/text_window_console.sv =====
// top level of the text window console: window registers, front end, back end
//
// Input beats (mode, char_code, read_col, read_row) enter when push is high
// and full is low. Each beat gives one result beat (cell_char, cursor_col,
// cursor_line, scrolled), shown while empty is low and taken with pop.
// A classifying front end feeds a two-entry command queue; the back end
// owns the character store (one write and one registered read per cycle)
// and the cursor, and hands results to a two-entry result queue.
// A put writes the character, adding a newline step when it wraps; a read
// waits for the registered store read; the unused mode just gives a result.
// A scroll copies each interior cell above the bottom row up from the row
// below, then blanks the bottom row; a clear writes each interior cell
// (store columns only; one store port). After reset the store is swept to
// zero, all SCREEN_COLS*SCREEN_ROWS cells (2000 by default), with full held
// high; register writes are taken then. When pop stays low, the result queue
// fills, then the command queue, and full rises; nothing is lost. Window
// registers are written over the APB port at byte addresses 0, 4, 8, 12;
// the user must change them only while idle; the block does not enforce it.
module text_window_console #(
	parameter int SCREEN_COLS = twc_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = twc_pkg::SCREEN_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 mode,
	input  logic [7:0]                 char_code,
	input  logic [6:0]                 read_col,
	input  logic [4:0]                 read_row,
	output logic                       empty,
	input  logic                       pop,
	output logic [7:0]                 cell_char,
	output logic [6:0]                 cursor_col,
	output logic [4:0]                 cursor_line,
	output logic                       scrolled,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [twc_pkg::ADDR_W-1:0] paddr,
	input  logic [twc_pkg::DATA_W-1:0] pwdata,
	output logic [twc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	twc_pkg::cfg_t     cfg_q;
	twc_pkg::reg_idx_t reg_idx;
	twc_pkg::cmd_t     cmd;
	twc_pkg::res_t     res_in;
	twc_pkg::res_t     res_out;
	logic              cmd_valid;
	logic              cmd_pop;
	logic              res_full;
	logic              res_push;
	logic              clearing;
	logic              cfg_we;

	assign pready  = 1'b1;
	assign reg_idx = twc_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_col    <= twc_pkg::RST_WIN_COL;
			cfg_q.win_row    <= twc_pkg::RST_WIN_ROW;
			cfg_q.win_width  <= twc_pkg::RST_WIN_WIDTH;
			cfg_q.win_height <= twc_pkg::RST_WIN_HEIGHT;
		end else if (cfg_we) begin
			case (reg_idx)
				twc_pkg::REG_WIN_COL:    cfg_q.win_col    <= pwdata[6:0];
				twc_pkg::REG_WIN_ROW:    cfg_q.win_row    <= pwdata[4:0];
				twc_pkg::REG_WIN_WIDTH:  cfg_q.win_width  <= pwdata[6:0];
				twc_pkg::REG_WIN_HEIGHT: cfg_q.win_height <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			twc_pkg::REG_WIN_COL:    prdata = twc_pkg::DATA_W'(cfg_q.win_col);
			twc_pkg::REG_WIN_ROW:    prdata = twc_pkg::DATA_W'(cfg_q.win_row);
			twc_pkg::REG_WIN_WIDTH:  prdata = twc_pkg::DATA_W'(cfg_q.win_width);
			twc_pkg::REG_WIN_HEIGHT: prdata = twc_pkg::DATA_W'(cfg_q.win_height);
			default:                 prdata = '0;
		endcase
	end

	twc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.hold      (clearing),
		.mode      (mode),
		.char_code (char_code),
		.read_col  (read_col),
		.read_row  (read_row),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	twc_back #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in),
		.clearing  (clearing)
	);

	twc_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.empty  (empty),
		.pop    (pop),
		.dout   (res_out)
	);

	assign cell_char   = res_out.cell_char;
	assign cursor_col  = res_out.cursor_col;
	assign cursor_line = res_out.cursor_line;
	assign scrolled    = res_out.scrolled;

endmodule

// ===== design/twc_front.sv =====
// front end: classifies incoming beats and queues them as commands
module twc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             hold,
	input  logic [1:0]       mode,
	input  logic [7:0]       char_code,
	input  logic [6:0]       read_col,
	input  logic [4:0]       read_row,
	output logic             full,
	output logic             cmd_valid,
	output twc_pkg::cmd_t    cmd,
	input  logic             cmd_pop
);

	twc_pkg::cmd_t new_cmd;
	twc_pkg::cmd_t q_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push_ok;
	logic          pop_ok;

	always_comb begin
		new_cmd.code = char_code;
		new_cmd.rcol = read_col;
		new_cmd.rrow = read_row;
		case (mode)
			twc_pkg::MODE_PUT: begin
				new_cmd.op = (char_code == twc_pkg::CODE_NEWLINE) ?
					twc_pkg::OP_NEWLINE : twc_pkg::OP_PUT;
			end
			twc_pkg::MODE_CLEAR: new_cmd.op = twc_pkg::OP_CLEAR;
			twc_pkg::MODE_READ:  new_cmd.op = twc_pkg::OP_READ;
			default:             new_cmd.op = twc_pkg::OP_NONE;
		endcase
	end

	assign full      = (cnt_q == 2'd2) || hold;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/twc_res_fifo.sv =====
// two-entry result queue in front of the output port
module twc_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  twc_pkg::res_t din,
	output logic          full,
	output logic          empty,
	input  logic          pop,
	output twc_pkg::res_t dout
);

	twc_pkg::res_t q_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push_ok;
	logic          pop_ok;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign dout    = q_q[rd_ptr_q];
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/twc_back.sv =====
// back end: character store, cursor and the put, scroll, fill and read sequencer
module twc_back #(
	parameter int SCREEN_COLS = twc_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = twc_pkg::SCREEN_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  twc_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  twc_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output twc_pkg::res_t res,
	output logic          clearing
);

	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0]            LAST_ADDR = AW'(CELLS - 1);
	localparam logic [twc_pkg::COLW-1:0] COLS_C    = twc_pkg::COLW'(SCREEN_COLS);
	localparam logic [twc_pkg::ROWW-1:0] ROWS_C    = twc_pkg::ROWW'(SCREEN_ROWS);

	function automatic logic [AW-1:0] cell_addr(input logic [twc_pkg::COLW-1:0] c,
			input logic [twc_pkg::ROWW-1:0] r);
		return AW'(int'(r) * SCREEN_COLS + int'(c));
	endfunction

	function automatic logic cell_in(input logic [twc_pkg::COLW-1:0] c,
			input logic [twc_pkg::ROWW-1:0] r);
		return (c < COLS_C) && (r < ROWS_C);
	endfunction

	twc_pkg::state_t state_q, state_d;
	twc_pkg::cmd_t   cmd_q;
	logic [6:0]      cur_col_q;
	logic [4:0]      cur_row_q;
	logic [twc_pkg::COLW-1:0] i_q;
	logic [twc_pkg::ROWW-1:0] j_q;
	logic            scr_q;
	logic            src_in_q;
	logic [7:0]      cell_q;
	logic [AW-1:0]   clr_q;

	logic [7:0]      mem [CELLS];
	logic [7:0]      rdata_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [AW-1:0]   mem_raddr;
	logic [7:0]      mem_wdata;

	logic [twc_pkg::COLW-1:0] col_sum, col_first, put_col, rd_col;
	logic [twc_pkg::ROWW-1:0] row_sum, row_first, put_row, rd_row, src_row, blank_row;
	logic col_range, col_more, scr_rows, scr_more, fill_rows, fill_more;
	logic blank_ok, col_adv, row_adv;

	always_comb begin
		col_sum   = twc_pkg::COLW'(cfg.win_col) + twc_pkg::COLW'(cfg.win_width);
		row_sum   = twc_pkg::ROWW'(cfg.win_row) + twc_pkg::ROWW'(cfg.win_height);
		col_first = twc_pkg::COLW'(cfg.win_col) + 1'b1;
		row_first = twc_pkg::ROWW'(cfg.win_row) + 1'b1;
		put_col   = twc_pkg::COLW'(cur_col_q) + twc_pkg::COLW'(cfg.win_col) + 1'b1;
		put_row   = twc_pkg::ROWW'(cur_row_q) + twc_pkg::ROWW'(cfg.win_row) + 1'b1;
		rd_col    = twc_pkg::COLW'(cmd_q.rcol);
		rd_row    = twc_pkg::ROWW'(cmd_q.rrow);
		src_row   = j_q + 1'b1;
		blank_row = row_sum - twc_pkg::ROWW'(2);
		blank_ok  = (row_sum >= twc_pkg::ROWW'(2));
		col_range = (col_first + 1 < col_sum) && (col_first < COLS_C);
		col_more  = (i_q + 2 < col_sum) && (i_q + 1 < COLS_C);
		scr_rows  = (row_first + 2 < row_sum);
		scr_more  = (j_q + 3 < row_sum);
		fill_rows = (row_first + 1 < row_sum);
		fill_more = (j_q + 2 < row_sum);
		col_adv   = (cur_col_q + 3 < cfg.win_width + 0);
		row_adv   = (cur_row_q + 3 < cfg.win_height + 0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			twc_pkg::ST_CLR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = twc_pkg::ST_IDLE;
				end
			end
			twc_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						twc_pkg::OP_PUT:     state_d = twc_pkg::ST_PUT;
						twc_pkg::OP_NEWLINE: state_d = twc_pkg::ST_LINE;
						twc_pkg::OP_CLEAR: begin
							state_d = (col_range && fill_rows) ?
								twc_pkg::ST_FILL : twc_pkg::ST_DONE;
						end
						twc_pkg::OP_READ:    state_d = twc_pkg::ST_RD;
						default:             state_d = twc_pkg::ST_DONE;
					endcase
				end
			end
			twc_pkg::ST_PUT: begin
				state_d = col_adv ? twc_pkg::ST_DONE : twc_pkg::ST_LINE;
			end
			twc_pkg::ST_LINE: begin
				if (row_adv || !col_range) begin
					state_d = twc_pkg::ST_DONE;
				end else begin
					state_d = scr_rows ? twc_pkg::ST_SCR_RD : twc_pkg::ST_BLANK;
				end
			end
			twc_pkg::ST_SCR_RD: state_d = twc_pkg::ST_SCR_WR;
			twc_pkg::ST_SCR_WR: begin
				state_d = (scr_more || col_more) ? twc_pkg::ST_SCR_RD : twc_pkg::ST_BLANK;
			end
			twc_pkg::ST_BLANK: begin
				if (!col_more) begin
					state_d = twc_pkg::ST_DONE;
				end
			end
			twc_pkg::ST_FILL: begin
				if (!fill_more && !col_more) begin
					state_d = twc_pkg::ST_DONE;
				end
			end
			twc_pkg::ST_RD:      state_d = twc_pkg::ST_RD_WAIT;
			twc_pkg::ST_RD_WAIT: state_d = twc_pkg::ST_DONE;
			twc_pkg::ST_DONE: begin
				if (!res_full) begin
					state_d = twc_pkg::ST_IDLE;
				end
			end
			default: state_d = twc_pkg::ST_IDLE;
		endcase
	end

	// outputs and store access
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 8'd0;
		mem_raddr = cell_addr(i_q, src_row);
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		clearing  = 1'b0;
		case (state_q)
			twc_pkg::ST_CLR: begin
				clearing = 1'b1;
				mem_we   = 1'b1;
			end
			twc_pkg::ST_IDLE: cmd_pop = cmd_valid;
			twc_pkg::ST_PUT: begin
				mem_we    = cell_in(put_col, put_row);
				mem_waddr = cell_addr(put_col, put_row);
				mem_wdata = cmd_q.code;
			end
			twc_pkg::ST_SCR_WR: begin
				mem_we    = cell_in(i_q, j_q);
				mem_waddr = cell_addr(i_q, j_q);
				mem_wdata = src_in_q ? rdata_q : 8'd0;
			end
			twc_pkg::ST_BLANK: begin
				mem_we    = blank_ok && cell_in(i_q, blank_row);
				mem_waddr = cell_addr(i_q, blank_row);
				mem_wdata = twc_pkg::CODE_SPACE;
			end
			twc_pkg::ST_FILL: begin
				mem_we    = cell_in(i_q, j_q);
				mem_waddr = cell_addr(i_q, j_q);
				mem_wdata = twc_pkg::CODE_SPACE;
			end
			twc_pkg::ST_RD:   mem_raddr = cell_addr(rd_col, rd_row);
			twc_pkg::ST_DONE: res_push = !res_full;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			twc_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q  <= cmd;
					cell_q <= 8'd0;
					i_q    <= col_first;
					j_q    <= row_first;
				end
			end
			twc_pkg::ST_LINE: begin
				i_q <= col_first;
				j_q <= row_first;
			end
			twc_pkg::ST_SCR_RD: src_in_q <= cell_in(i_q, src_row);
			twc_pkg::ST_SCR_WR: begin
				if (scr_more) begin
					j_q <= j_q + 1'b1;
				end else if (col_more) begin
					i_q <= i_q + 1'b1;
					j_q <= row_first;
				end else begin
					i_q <= col_first;
				end
			end
			twc_pkg::ST_BLANK: begin
				if (col_more) begin
					i_q <= i_q + 1'b1;
				end
			end
			twc_pkg::ST_FILL: begin
				if (fill_more) begin
					j_q <= j_q + 1'b1;
				end else if (col_more) begin
					i_q <= i_q + 1'b1;
					j_q <= row_first;
				end
			end
			twc_pkg::ST_RD:      src_in_q <= cell_in(rd_col, rd_row);
			twc_pkg::ST_RD_WAIT: cell_q <= src_in_q ? rdata_q : 8'd0;
			default: begin
			end
		endcase
	end

	// control side: state, cursor, clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= twc_pkg::ST_CLR;
			clr_q     <= '0;
			cur_col_q <= 7'd0;
			cur_row_q <= 5'd0;
			scr_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				twc_pkg::ST_CLR:  clr_q <= clr_q + 1'b1;
				twc_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						scr_q <= 1'b0;
					end
				end
				twc_pkg::ST_PUT: begin
					if (col_adv) begin
						cur_col_q <= cur_col_q + 7'd1;
					end
				end
				twc_pkg::ST_LINE: begin
					cur_col_q <= 7'd0;
					if (row_adv) begin
						cur_row_q <= cur_row_q + 5'd1;
					end else begin
						scr_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res.cell_char   = cell_q;
	assign res.cursor_col  = cur_col_q;
	assign res.cursor_line = cur_row_q;
	assign res.scrolled    = scr_q;

endmodule

// ===== verif/twc_screen_checker.sv =====
`timescale 1ns / 100ps
// screen store and cursor predictor with result checking for text_window_console
module twc_screen_checker #(
	parameter int SCREEN_COLS = twc_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = twc_pkg::SCREEN_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic [1:0]                 mode,
	input  logic [7:0]                 char_code,
	input  logic [6:0]                 read_col,
	input  logic [4:0]                 read_row,
	input  logic                       empty,
	input  logic                       pop,
	input  logic [7:0]                 cell_char,
	input  logic [6:0]                 cursor_col,
	input  logic [4:0]                 cursor_line,
	input  logic                       scrolled,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [twc_pkg::ADDR_W-1:0] paddr,
	input  logic [twc_pkg::DATA_W-1:0] pwdata,
	input  logic                       pready,
	output int                         fail_count
);

	logic [7:0] scr_mem [SCREEN_COLS*SCREEN_ROWS];
	int cur_col;
	int cur_row;
	int win_c;
	int win_r;
	int win_w;
	int win_h;
	int n_bad;
	twc_pkg::res_t pending_results[$];

	task automatic report_mismatch(string msg);
		$display("%0t twc check: %s", $time, msg);
		n_bad++;
	endtask

	function automatic logic [7:0] cell_rd(int col, int row);
		if (col < 0 || col >= SCREEN_COLS || row < 0 || row >= SCREEN_ROWS)
			return 8'h00;
		return scr_mem[row*SCREEN_COLS + col];
	endfunction

	function automatic void cell_wr(int col, int row, logic [7:0] v);
		if (col >= 0 && col < SCREEN_COLS && row >= 0 && row < SCREEN_ROWS)
			scr_mem[row*SCREEN_COLS + col] = v;
	endfunction

	// next interior line, or scroll the interior up when on the last one
	function automatic logic line_feed();
		int i;
		int j;
		if (cur_row < win_h - 3) begin
			cur_row++;
			cur_col = 0;
			return 1'b0;
		end
		for (i = win_c + 1; i < win_c + win_w - 1; i++)
			for (j = win_r + 1; j < win_r + win_h - 2; j++)
				cell_wr(i, j, cell_rd(i, j + 1));
		for (i = win_c + 1; i < win_c + win_w - 1; i++)
			cell_wr(i, win_r + win_h - 2, twc_pkg::CODE_SPACE);
		cur_col = 0;
		return 1'b1;
	endfunction

	function automatic twc_pkg::res_t console_step(logic [1:0] m, logic [7:0] c,
		logic [6:0] rc, logic [4:0] rr);
		twc_pkg::res_t r;
		int x;
		int y;
		r = '0;
		if (m == twc_pkg::MODE_PUT) begin
			if (c == twc_pkg::CODE_NEWLINE) begin
				r.scrolled = line_feed();
			end else begin
				cell_wr(cur_col + 1 + win_c, cur_row + 1 + win_r, c);
				if (cur_col < win_w - 3)
					cur_col++;
				else
					r.scrolled = line_feed();
			end
		end else if (m == twc_pkg::MODE_CLEAR) begin
			for (x = 1; x < win_w - 1; x++)
				for (y = 1; y < win_h - 1; y++)
					cell_wr(x + win_c, y + win_r, twc_pkg::CODE_SPACE);
		end else if (m == twc_pkg::MODE_READ) begin
			r.cell_char = cell_rd(int'(rc), int'(rr));
		end
		r.cursor_col = 7'(cur_col);
		r.cursor_line = 5'(cur_row);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		twc_pkg::res_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < SCREEN_COLS*SCREEN_ROWS; i++)
				scr_mem[i] = 8'h00;
			cur_col = 0;
			cur_row = 0;
			win_c = int'(twc_pkg::RST_WIN_COL);
			win_r = int'(twc_pkg::RST_WIN_ROW);
			win_w = int'(twc_pkg::RST_WIN_WIDTH);
			win_h = int'(twc_pkg::RST_WIN_HEIGHT);
			n_bad = 0;
			pending_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (twc_pkg::reg_idx_t'(paddr[3:2]))
					twc_pkg::REG_WIN_COL:    win_c = int'(pwdata[6:0]);
					twc_pkg::REG_WIN_ROW:    win_r = int'(pwdata[4:0]);
					twc_pkg::REG_WIN_WIDTH:  win_w = int'(pwdata[6:0]);
					twc_pkg::REG_WIN_HEIGHT: win_h = int'(pwdata[4:0]);
					default: ;
				endcase
			end
			if (push && !full)
				pending_results.push_back(console_step(mode, char_code, read_col, read_row));
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result beat with none expected (col %0d line %0d)",
						cursor_col, cursor_line));
				end else begin
					want = pending_results.pop_front();
					if (cell_char !== want.cell_char)
						report_mismatch($sformatf("cell_char got %0h want %0h",
							cell_char, want.cell_char));
					if (cursor_col !== want.cursor_col)
						report_mismatch($sformatf("cursor_col got %0d want %0d",
							cursor_col, want.cursor_col));
					if (cursor_line !== want.cursor_line)
						report_mismatch($sformatf("cursor_line got %0d want %0d",
							cursor_line, want.cursor_line));
					if (scrolled !== want.scrolled)
						report_mismatch($sformatf("scrolled got %0b want %0b",
							scrolled, want.scrolled));
				end
			end
		end
		fail_count = n_bad + pending_results.size();
	end

endmodule

// ===== verif/text_window_console_tb.sv =====
`timescale 1ns / 100ps
// testbench top for text_window_console: clock, reset, stimulus, window setup and verdict
module text_window_console_tb;

	localparam logic [1:0] MODE_IDLE = 2'd3;
	localparam int N_PHASE = 10;

	logic                       clk;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic [1:0]                 mode;
	logic [7:0]                 char_code;
	logic [6:0]                 read_col;
	logic [4:0]                 read_row;
	logic                       empty;
	logic                       pop;
	logic [7:0]                 cell_char;
	logic [6:0]                 cursor_col;
	logic [4:0]                 cursor_line;
	logic                       scrolled;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [twc_pkg::ADDR_W-1:0] paddr;
	logic [twc_pkg::DATA_W-1:0] pwdata;
	logic [twc_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	int fail_count;
	int n_sent = 0;
	int n_done = 0;
	int send_pct = 12;
	int recv_pct = 63;

	// window setups: position, size including frame, and beats in that setup
	int ph_col[N_PHASE]   = '{5, 77, 0, 40, 127, 0, 1, 10, 20, 0};
	int ph_row[N_PHASE]   = '{3, 22, 0, 10, 31, 0, 1, 5, 2, 0};
	int ph_w[N_PHASE]     = '{10, 80, 3, 20, 0, 127, 78, 2, 6, 80};
	int ph_h[N_PHASE]     = '{6, 25, 3, 8, 0, 31, 23, 1, 20, 25};
	int ph_beats[N_PHASE] = '{300, 150, 200, 300, 100, 100, 200, 100, 200, 200};

	text_window_console u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.char_code  (char_code),
		.read_col   (read_col),
		.read_row   (read_row),
		.empty      (empty),
		.pop        (pop),
		.cell_char  (cell_char),
		.cursor_col (cursor_col),
		.cursor_line(cursor_line),
		.scrolled   (scrolled),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	twc_screen_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.char_code  (char_code),
		.read_col   (read_col),
		.read_row   (read_row),
		.empty      (empty),
		.pop        (pop),
		.cell_char  (cell_char),
		.cursor_col (cursor_col),
		.cursor_line(cursor_line),
		.scrolled   (scrolled),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("text_window_console_tb: errors");
		$finish;
	end

	// result side: random stalls plus two long hold-offs that back the block up
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				n_done++;
				if (n_done == 150 || n_done == 1100)
					hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_pct);
			end
		end
	end

	task automatic send_beat(logic [1:0] m, logic [7:0] c, logic [6:0] rc, logic [4:0] rr);
		while ($urandom_range(99) < send_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		char_code <= c;
		read_col <= rc;
		read_row <= rr;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do
			@(negedge clk);
		while (n_done != n_sent);
		@(posedge clk);
	endtask

	task automatic cfg_write(twc_pkg::reg_idx_t r, logic [twc_pkg::DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(int wc, int wr, int ww, int wh);
		wait_drained();
		cfg_write(twc_pkg::REG_WIN_COL, twc_pkg::DATA_W'(wc));
		cfg_write(twc_pkg::REG_WIN_ROW, twc_pkg::DATA_W'(wr));
		cfg_write(twc_pkg::REG_WIN_WIDTH, twc_pkg::DATA_W'(ww));
		cfg_write(twc_pkg::REG_WIN_HEIGHT, twc_pkg::DATA_W'(wh));
	endtask

	task automatic rand_beat(int wc, int wr, int ww, int wh);
		int pick;
		logic [1:0] m;
		logic [7:0] c;
		logic [6:0] rc;
		logic [4:0] rr;
		pick = $urandom_range(99);
		c = 8'($urandom_range(255));
		rc = 7'($urandom_range(127));
		rr = 5'($urandom_range(31));
		if (pick < 72) begin
			m = twc_pkg::MODE_PUT;
		end else if (pick < 80) begin
			m = twc_pkg::MODE_PUT;
			c = twc_pkg::CODE_NEWLINE;
		end else if (pick < 83) begin
			m = twc_pkg::MODE_CLEAR;
		end else if (pick < 98) begin
			m = twc_pkg::MODE_READ;
			if ($urandom_range(1)) begin
				rc = 7'(wc + $urandom_range(ww));
				rr = 5'(wr + $urandom_range(wh));
			end else if ($urandom_range(7) != 0) begin
				rc = 7'($urandom_range(79));
				rr = 5'($urandom_range(24));
			end
		end else begin
			m = MODE_IDLE;
		end
		send_beat(m, c, rc, rr);
	endtask

	initial begin
		int p;
		int k;
		int n_rand;
		push = 1'b0;
		mode = twc_pkg::MODE_PUT;
		char_code = 8'h00;
		read_col = 7'd0;
		read_row = 5'd0;
		pop = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		n_rand = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-screen window after reset: corner reads, unused mode, puts, clear
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_READ, 8'hff, 7'd79, 5'd24);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd127, 5'd31);
		send_beat(MODE_IDLE, 8'hff, 7'd127, 5'd31);
		send_beat(twc_pkg::MODE_PUT, 8'h41, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_PUT, 8'h00, 7'd127, 5'd31);
		send_beat(twc_pkg::MODE_PUT, 8'hff, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_PUT, twc_pkg::CODE_NEWLINE, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_PUT, 8'h7e, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd1, 5'd1);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd3, 5'd1);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd1, 5'd2);
		send_beat(twc_pkg::MODE_CLEAR, 8'hff, 7'd127, 5'd31);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd1, 5'd1);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd79, 5'd24);

		// 2x2 interior with the cursor left on its last cell: wrap and scroll at once
		set_window(2, 1, 4, 4);
		send_beat(twc_pkg::MODE_PUT, 8'h61, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_PUT, 8'h62, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_PUT, 8'h63, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_PUT, twc_pkg::CODE_NEWLINE, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd3, 5'd2);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd4, 5'd2);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd3, 5'd3);
		send_beat(twc_pkg::MODE_CLEAR, 8'h00, 7'd0, 5'd0);
		send_beat(twc_pkg::MODE_READ, 8'h00, 7'd3, 5'd2);

		for (p = 0; p < N_PHASE; p++) begin
			set_window(ph_col[p], ph_row[p], ph_w[p], ph_h[p]);
			for (k = 0; k < ph_beats[p]; k++) begin
				if (n_rand < 600) begin
					send_pct = 12;
					recv_pct = 63;
				end else if (n_rand < 1200) begin
					send_pct = 63;
					recv_pct = 12;
				end else begin
					send_pct = 0;
					recv_pct = 0;
				end
				rand_beat(ph_col[p], ph_row[p], ph_w[p], ph_h[p]);
				n_rand++;
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("text_window_console_tb: clean");
		else
			$display("text_window_console_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
design/twc_pkg.sv
design/twc_front.sv
design/twc_res_fifo.sv
design/twc_back.sv
design/text_window_console.sv
verif/twc_screen_checker.sv
verif/text_window_console_tb.sv
